>>> design/awbw_pkg.sv
// Shared widths, register indexes, sensor addresses and the item struct
// for the AWB gain register writer. No dependencies.
package awbw_pkg;

  localparam int unsigned RATIO_W   = 10;   // measured and typical ratios
  localparam int unsigned ADDR_W    = 8;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Correction ratio divide: typ * 1000 / measured
  localparam int unsigned CORR_W    = 20;   // 1023 * 1000 < 2**20
  // Gain divide: 0x80 * ratio / base
  localparam int unsigned GAIN_SHIFT = 7;
  localparam int unsigned SCALED_W   = CORR_W + GAIN_SHIFT;

  localparam int unsigned DIV_BPS   = 2;    // quotient bits resolved per stage

  localparam int unsigned PERMILLE  = 1000;

  localparam logic [CFG_IDX_W-1:0] CFG_TYP_RED  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TYP_BLUE = 1'd1;
  localparam logic [RATIO_W-1:0]   TYP_RATIO_RESET = 10'd512;

  localparam logic [VALUE_W-1:0] UNITY_GAIN = 16'h0080;

  localparam logic [ADDR_W-1:0]  PAGE_ADDR     = 8'hfd;
  localparam logic [VALUE_W-1:0] PAGE_VALUE    = 16'h0002;
  localparam logic [ADDR_W-1:0]  RED_ADDR      = 8'h10;
  localparam logic [ADDR_W-1:0]  GREEN_ADDR_A  = 8'h13;
  localparam logic [ADDR_W-1:0]  GREEN_ADDR_B  = 8'h14;
  localparam logic [ADDR_W-1:0]  BLUE_ADDR     = 8'h11;
  localparam logic [ADDR_W-1:0]  UPDATE_ADDR   = 8'h01;
  localparam logic [VALUE_W-1:0] UPDATE_VALUE  = 16'h0001;
  localparam logic [ADDR_W-1:0]  ERR_ADDR      = 8'h00;
  localparam logic [VALUE_W-1:0] ERR_VALUE     = 16'h0000;

  // One finished item handed from the pipeline to the write sequencer
  typedef struct packed {
    logic [VALUE_W-1:0] gain_r;
    logic [VALUE_W-1:0] gain_g;
    logic [VALUE_W-1:0] gain_b;
    logic               en_r;
    logic               en_g;
    logic               en_b;
    logic               err;
  } awbw_item_t;

endpackage

>>> design/awbw_div.sv
// Pipelined restoring unsigned divider, BPS quotient bits per stage.
// Uses no package items; stalls on en low.
module awbw_div #(
  parameter int unsigned NUM_W = 20,
  parameter int unsigned DEN_W = 10,
  parameter int unsigned BPS   = 2
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  localparam int unsigned STAGES = (NUM_W + BPS - 1) / BPS;

  logic [NUM_W-1:0] st_n [STAGES];
  logic [NUM_W-1:0] st_q [STAGES];
  logic [DEN_W-1:0] st_r [STAGES];
  logic [DEN_W-1:0] st_d [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [NUM_W-1:0] n_in, q_in, n_next, q_next;
    logic [DEN_W-1:0] r_in, d_in, r_next;

    if (s == 0) begin : g_first
      assign n_in = num;
      assign q_in = '0;
      assign r_in = '0;
      assign d_in = den;
    end else begin : g_later
      assign n_in = st_n[s-1];
      assign q_in = st_q[s-1];
      assign r_in = st_r[s-1];
      assign d_in = st_d[s-1];
    end

    always_comb begin : step
      logic [DEN_W:0] t;
      t      = '0;
      n_next = n_in;
      q_next = q_in;
      r_next = r_in;
      for (int j = 0; j < BPS; j++) begin
        if (s * BPS + j < NUM_W) begin
          t      = {r_next, n_next[NUM_W-1]};
          n_next = n_next << 1;
          if (t >= {1'b0, d_in}) begin
            r_next = DEN_W'(t - {1'b0, d_in});
            q_next = {q_next[NUM_W-2:0], 1'b1};
          end else begin
            r_next = t[DEN_W-1:0];
            q_next = {q_next[NUM_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_n[s] <= n_next;
        st_q[s] <= q_next;
        st_r[s] <= r_next;
        st_d[s] <= d_in;
      end
    end
  end

  assign quo = st_q[STAGES-1];

endmodule

>>> design/awbw_seq.sv
// Write sequencer: expands one gain item into register-write beats.
// Depends on awbw_pkg.
module awbw_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  input  awbw_pkg::awbw_item_t       item,
  output logic                       item_ready,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [awbw_pkg::ADDR_W-1:0]  out_address,
  output logic [awbw_pkg::VALUE_W-1:0] out_value,
  output logic                       out_last,
  output logic                       out_error
);

  typedef enum logic [1:0] {SEG_RED, SEG_GREEN, SEG_BLUE, SEG_ERR} seg_t;

  seg_t                 seg, seg_first, seg_after;
  logic [1:0]           pos;
  logic                 busy;
  awbw_pkg::awbw_item_t hold;

  logic                          emit, seg_end, has_after, done, load, item_any;
  logic [awbw_pkg::ADDR_W-1:0]   bt_addr;
  logic [awbw_pkg::VALUE_W-1:0]  bt_value;

  always_comb begin
    bt_addr  = awbw_pkg::PAGE_ADDR;
    bt_value = awbw_pkg::PAGE_VALUE;
    seg_end  = 1'b0;
    unique case (seg)
      SEG_RED, SEG_BLUE: begin
        case (pos)
          2'd0: ;
          2'd1: begin
            bt_addr  = (seg == SEG_RED) ? awbw_pkg::RED_ADDR : awbw_pkg::BLUE_ADDR;
            bt_value = (seg == SEG_RED) ? hold.gain_r : hold.gain_b;
          end
          default: begin
            bt_addr  = awbw_pkg::UPDATE_ADDR;
            bt_value = awbw_pkg::UPDATE_VALUE;
            seg_end  = 1'b1;
          end
        endcase
      end
      SEG_GREEN: begin
        case (pos)
          2'd0: ;
          2'd1: begin
            bt_addr  = awbw_pkg::GREEN_ADDR_A;
            bt_value = hold.gain_g;
          end
          2'd2: begin
            bt_addr  = awbw_pkg::GREEN_ADDR_B;
            bt_value = hold.gain_g;
          end
          default: begin
            bt_addr  = awbw_pkg::UPDATE_ADDR;
            bt_value = awbw_pkg::UPDATE_VALUE;
            seg_end  = 1'b1;
          end
        endcase
      end
      default: begin
        bt_addr  = awbw_pkg::ERR_ADDR;
        bt_value = awbw_pkg::ERR_VALUE;
        seg_end  = 1'b1;
      end
    endcase
  end

  // Next enabled sequence after the current one
  always_comb begin
    has_after = 1'b0;
    seg_after = SEG_BLUE;
    unique case (seg)
      SEG_RED: begin
        if (hold.en_g) begin
          has_after = 1'b1;
          seg_after = SEG_GREEN;
        end else if (hold.en_b) begin
          has_after = 1'b1;
        end
      end
      SEG_GREEN: has_after = hold.en_b;
      default: ;
    endcase
  end

  always_comb begin
    if (item.err) seg_first = SEG_ERR;
    else if (item.en_r) seg_first = SEG_RED;
    else if (item.en_g) seg_first = SEG_GREEN;
    else seg_first = SEG_BLUE;
  end

  assign item_any   = item.err | item.en_r | item.en_g | item.en_b;
  assign emit       = busy && (!out_valid || out_ready);
  assign done       = seg_end && !has_after;
  assign item_ready = !busy || (emit && done);
  assign load       = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      seg       <= SEG_RED;
      pos       <= '0;
    end else begin
      if (emit) begin
        out_valid   <= 1'b1;
        out_address <= bt_addr;
        out_value   <= bt_value;
        out_last    <= done && (seg != SEG_ERR);
        out_error   <= (seg == SEG_ERR);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // a load while busy only happens on the final beat of the held item
      if (load) begin
        hold <= item;
        seg  <= seg_first;
        pos  <= '0;
        busy <= item_any;
      end else if (emit) begin
        if (seg_end) begin
          seg  <= seg_after;
          pos  <= '0;
          busy <= has_after;
        end else begin
          pos <= pos + 2'd1;
        end
      end
    end
  end

endmodule

>>> design/awb_gain_register_writer_core.sv
// AWB gain register writer: ratio divide pipeline feeding a write sequencer.
// Depends on awbw_pkg, awbw_div and awbw_seq.
//
// Usage
//   Input channel (in_valid/in_ready): one beat carries a measured red/green
//   and blue/green ratio pair. Output channel (out_valid/out_ready): each beat
//   is one sensor register write; last_write marks the final write of an
//   item, divide_error marks the single beat sent for a zero divisor.
//   Config port: cfg_write with cfg_index/cfg_data sets the golden ratios;
//   write it only while no item is in flight.
// Path from accept to out_valid: input stage, ceil(20/BPS) correction-divide
//   stages, base stage, ceil(27/BPS) gain-divide stages, saturate stage,
//   sequencer load and the output register.
// Throughput: a new item can enter every cycle while in_ready is high; the
//   output register emits one beat per cycle while out_ready is high. Each
//   item takes 0 to 10 beats, one per write; that sets the sustained rate.
// Reset: synchronous; empties the pipeline and sequencer and loads both
//   golden ratios with 512.
// Stall: when out_ready is low the output beat holds; the whole divide
//   pipeline freezes once its last stage holds an item the sequencer cannot
//   take, and in_ready drops. Nothing is lost or repeated.
module awb_gain_register_writer_core #(
  parameter int unsigned DIV_BPS = awbw_pkg::DIV_BPS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [awbw_pkg::RATIO_W-1:0]    red_ratio,
  input  logic [awbw_pkg::RATIO_W-1:0]    blue_ratio,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [awbw_pkg::ADDR_W-1:0]     reg_address,
  output logic [awbw_pkg::VALUE_W-1:0]    reg_value,
  output logic                            last_write,
  output logic                            divide_error,
  input  logic                            cfg_write,
  input  logic [awbw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [awbw_pkg::RATIO_W-1:0]    cfg_data
);

  localparam int unsigned CORR_W   = awbw_pkg::CORR_W;
  localparam int unsigned SCALED_W = awbw_pkg::SCALED_W;
  localparam int unsigned VALUE_W  = awbw_pkg::VALUE_W;
  localparam int unsigned DIV1_ST  = (CORR_W + DIV_BPS - 1) / DIV_BPS;
  localparam int unsigned DIV2_ST  = (SCALED_W + DIV_BPS - 1) / DIV_BPS;

  localparam logic [CORR_W-1:0]   BASE_UNITY  = CORR_W'(awbw_pkg::PERMILLE);
  localparam logic [SCALED_W-1:0] GREEN_SCALED =
    SCALED_W'(awbw_pkg::PERMILLE) << awbw_pkg::GAIN_SHIFT;

  // Golden ratios
  logic [awbw_pkg::RATIO_W-1:0] typ_red, typ_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      typ_red  <= awbw_pkg::TYP_RATIO_RESET;
      typ_blue <= awbw_pkg::TYP_RATIO_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        awbw_pkg::CFG_TYP_RED:  typ_red  <= cfg_data;
        awbw_pkg::CFG_TYP_BLUE: typ_blue <= cfg_data;
        default: ;
      endcase
    end
  end

  // Whole pipeline moves together; it only halts when the last stage is
  // full and the sequencer cannot take it.
  logic adv, sat_vld, item_ready;
  assign adv      = !sat_vld || item_ready;
  assign in_ready = adv;

  // Stage 0: scale golden ratios by 1000, flag zero measured ratios
  logic                         s0_vld, s0_err;
  logic [awbw_pkg::RATIO_W-1:0] s0_red, s0_blue;
  logic [CORR_W-1:0]            s0_num_r, s0_num_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (adv) begin
      s0_vld   <= in_valid;
      s0_err   <= (red_ratio == '0) || (blue_ratio == '0);
      s0_red   <= red_ratio;
      s0_blue  <= blue_ratio;
      s0_num_r <= CORR_W'(CORR_W'(typ_red) * BASE_UNITY);
      s0_num_b <= CORR_W'(CORR_W'(typ_blue) * BASE_UNITY);
    end
  end

  // Correction ratios cr, cb
  logic [CORR_W-1:0] cr, cb;

  awbw_div #(.NUM_W(CORR_W), .DEN_W(awbw_pkg::RATIO_W), .BPS(DIV_BPS)) u_div_cr (
    .clk(clk), .en(adv), .num(s0_num_r), .den(s0_red), .quo(cr)
  );
  awbw_div #(.NUM_W(CORR_W), .DEN_W(awbw_pkg::RATIO_W), .BPS(DIV_BPS)) u_div_cb (
    .clk(clk), .en(adv), .num(s0_num_b), .den(s0_blue), .quo(cb)
  );

  logic d1_vld [DIV1_ST];
  logic d1_err [DIV1_ST];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV1_ST; i++) d1_vld[i] <= 1'b0;
    end else if (adv) begin
      d1_vld[0] <= s0_vld;
      d1_err[0] <= s0_err;
      for (int i = 1; i < DIV1_ST; i++) begin
        d1_vld[i] <= d1_vld[i-1];
        d1_err[i] <= d1_err[i-1];
      end
    end
  end

  // Base stage: min of the two when either is below unity, else unity
  logic              b_vld, b_err;
  logic [CORR_W-1:0] b_cr, b_cb, b_base, base;

  always_comb begin
    if ((cr < BASE_UNITY) || (cb < BASE_UNITY)) base = (cr < cb) ? cr : cb;
    else base = BASE_UNITY;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (adv) begin
      b_vld  <= d1_vld[DIV1_ST-1];
      b_err  <= d1_err[DIV1_ST-1] || (base == '0);
      b_cr   <= cr;
      b_cb   <= cb;
      b_base <= base;
    end
  end

  // Gains 0x80 * ratio / base
  logic [SCALED_W-1:0] q_r, q_g, q_b;

  awbw_div #(.NUM_W(SCALED_W), .DEN_W(CORR_W), .BPS(DIV_BPS)) u_div_gr (
    .clk(clk), .en(adv), .num({b_cr, awbw_pkg::GAIN_SHIFT'(0)}), .den(b_base), .quo(q_r)
  );
  awbw_div #(.NUM_W(SCALED_W), .DEN_W(CORR_W), .BPS(DIV_BPS)) u_div_gg (
    .clk(clk), .en(adv), .num(GREEN_SCALED), .den(b_base), .quo(q_g)
  );
  awbw_div #(.NUM_W(SCALED_W), .DEN_W(CORR_W), .BPS(DIV_BPS)) u_div_gb (
    .clk(clk), .en(adv), .num({b_cb, awbw_pkg::GAIN_SHIFT'(0)}), .den(b_base), .quo(q_b)
  );

  logic d2_vld [DIV2_ST];
  logic d2_err [DIV2_ST];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV2_ST; i++) d2_vld[i] <= 1'b0;
    end else if (adv) begin
      d2_vld[0] <= b_vld;
      d2_err[0] <= b_err;
      for (int i = 1; i < DIV2_ST; i++) begin
        d2_vld[i] <= d2_vld[i-1];
        d2_err[i] <= d2_err[i-1];
      end
    end
  end

  // Saturate to 16 bits and flag gains above unity
  logic [VALUE_W-1:0]   g_r, g_g, g_b;
  awbw_pkg::awbw_item_t sat_item;

  assign g_r = (|q_r[SCALED_W-1:VALUE_W]) ? '1 : q_r[VALUE_W-1:0];
  assign g_g = (|q_g[SCALED_W-1:VALUE_W]) ? '1 : q_g[VALUE_W-1:0];
  assign g_b = (|q_b[SCALED_W-1:VALUE_W]) ? '1 : q_b[VALUE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_vld <= 1'b0;
    end else if (adv) begin
      sat_vld         <= d2_vld[DIV2_ST-1];
      sat_item.err    <= d2_err[DIV2_ST-1];
      sat_item.gain_r <= g_r;
      sat_item.gain_g <= g_g;
      sat_item.gain_b <= g_b;
      sat_item.en_r   <= g_r > awbw_pkg::UNITY_GAIN;
      sat_item.en_g   <= g_g > awbw_pkg::UNITY_GAIN;
      sat_item.en_b   <= g_b > awbw_pkg::UNITY_GAIN;
    end
  end

  awbw_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (sat_vld),
    .item        (sat_item),
    .item_ready  (item_ready),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_address (reg_address),
    .out_value   (reg_value),
    .out_last    (last_write),
    .out_error   (divide_error)
  );

  // Error beat is a lone zero write, never the marked last write
  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_error |->
      !last_write && (reg_address == awbw_pkg::ERR_ADDR) && (reg_value == awbw_pkg::ERR_VALUE))
    else $error("error beat carries write data");

  // A gain write is only issued for a gain above unity
  a_gain_above: assert property (@(posedge clk) disable iff (rst)
    out_valid && !divide_error &&
      ((reg_address == awbw_pkg::RED_ADDR) || (reg_address == awbw_pkg::BLUE_ADDR) ||
       (reg_address == awbw_pkg::GREEN_ADDR_A)) |-> reg_value > awbw_pkg::UNITY_GAIN)
    else $error("gain write at or below unity");

  // An empty last stage never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !sat_vld |-> in_ready)
    else $error("input stalled with empty pipeline tail");

  // Nothing leaves the block right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("output beat right after reset");

endmodule
